/* sv/swd_pkg.sv */
// Shared types, codes and the whitening table for the sync word deframer.
package swd_pkg;

    localparam int POS_W     = 9;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;
    localparam int WHITEN_W  = 6;

    localparam logic [KIND_W-1:0] KIND_DATA    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_KEPT    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DROPPED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_WORD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_ABOVE = 2'd1;

    localparam logic [31:0]      SYNC_WORD_RST  = 32'h8844_6948;
    localparam logic [POS_W-1:0] KEEP_ABOVE_RST = 9'd300;

    localparam logic [7:0] WHITEN_TAB [64] = '{
        8'h96, 8'h83, 8'h3E, 8'h51, 8'hB1, 8'h49, 8'h08, 8'h98,
        8'h32, 8'h05, 8'h59, 8'h0E, 8'hF9, 8'h44, 8'hC6, 8'h26,
        8'h21, 8'h60, 8'hC2, 8'hEA, 8'h79, 8'h5D, 8'h6D, 8'hA1,
        8'h54, 8'h69, 8'h47, 8'h0C, 8'hDC, 8'hE8, 8'h5C, 8'hF1,
        8'hF7, 8'h76, 8'h82, 8'h7F, 8'h07, 8'h99, 8'hA2, 8'h2C,
        8'h93, 8'h7C, 8'h30, 8'h63, 8'hF5, 8'h10, 8'h2E, 8'h61,
        8'hD0, 8'hBC, 8'hB4, 8'hB6, 8'h06, 8'hAA, 8'hF4, 8'h23,
        8'h78, 8'h6E, 8'h3B, 8'hAE, 8'hBF, 8'h7B, 8'h4C, 8'hC1
    };

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [7:0]        data_byte;
        logic [POS_W-1:0]  position;
        logic              frame_last;
    } t_result;

endpackage

/* sv/swd_core.sv */
// Sync hunt, byte packing and descrambling state, one item per step.
module swd_core #(
    parameter int FRAME_BYTES     = 320,
    parameter int SYNC_BITS       = 32,
    parameter int FIRST_DATA_BYTE = 7
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_step,
    input  logic                     i_opcode,
    input  logic                     i_data_bit,
    input  logic [31:0]              i_sync_word,
    input  logic [swd_pkg::POS_W-1:0] i_keep_above,
    output swd_pkg::t_result         o_result
);
    import swd_pkg::*;

    localparam int VB_W = $clog2(SYNC_BITS + 1);
    localparam logic [VB_W-1:0]  VB_FULL   = VB_W'(SYNC_BITS);
    localparam logic [POS_W-1:0] POS_FIRST = POS_W'(FIRST_DATA_BYTE);
    localparam logic [POS_W:0]   POS_END   = (POS_W + 1)'(FRAME_BYTES);

    logic [SYNC_BITS-1:0] r_window, n_window;
    logic [VB_W-1:0]      r_vbits, n_vbits;
    logic                 r_in_frame, n_in_frame;
    logic [2:0]           r_bit_idx, n_bit_idx;
    logic [7:0]           r_acc, n_acc;
    logic [POS_W-1:0]     r_pos, n_pos;

    logic [7:0]     acc_bit;
    logic [POS_W:0] pos_inc;
    logic           last;

    always_comb begin
        acc_bit = r_acc | (8'(i_data_bit) << r_bit_idx);
        pos_inc = {1'b0, r_pos} + (POS_W + 1)'(1);
        last    = (pos_inc >= POS_END);

        n_window   = r_window;
        n_vbits    = r_vbits;
        n_in_frame = r_in_frame;
        n_bit_idx  = r_bit_idx;
        n_acc      = r_acc;
        n_pos      = r_pos;
        o_result   = '0;

        if (i_opcode) begin
            // gap: drop the window history and any frame in progress
            n_vbits    = '0;
            n_in_frame = 1'b0;
            n_bit_idx  = '0;
            n_acc      = '0;
            n_pos      = POS_FIRST;
            if (r_in_frame) begin
                o_result.valid    = 1'b1;
                o_result.kind     = (r_pos > i_keep_above) ? KIND_KEPT : KIND_DROPPED;
                o_result.position = r_pos;
            end
        end else begin
            n_window = {r_window[SYNC_BITS-2:0], i_data_bit};
            if (r_vbits != VB_FULL) begin
                n_vbits = r_vbits + VB_W'(1);
            end
            if (!r_in_frame) begin
                if (n_vbits == VB_FULL && n_window == i_sync_word[SYNC_BITS-1:0]) begin
                    n_in_frame = 1'b1;
                    n_bit_idx  = '0;
                    n_acc      = '0;
                    n_pos      = POS_FIRST;
                end
            end else if (r_bit_idx != 3'd7) begin
                n_acc     = acc_bit;
                n_bit_idx = r_bit_idx + 3'd1;
            end else begin
                o_result.valid      = 1'b1;
                o_result.kind       = KIND_DATA;
                o_result.data_byte  = acc_bit ^ WHITEN_TAB[r_pos[WHITEN_W-1:0]];
                o_result.position   = r_pos;
                o_result.frame_last = last;
                n_acc     = '0;
                n_bit_idx = '0;
                if (last) begin
                    n_in_frame = 1'b0;
                    n_pos      = POS_FIRST;
                end else begin
                    n_pos = pos_inc[POS_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window   <= '0;
            r_vbits    <= '0;
            r_in_frame <= 1'b0;
            r_bit_idx  <= '0;
            r_acc      <= '0;
            r_pos      <= POS_FIRST;
        end else if (i_step) begin
            r_window   <= n_window;
            r_vbits    <= n_vbits;
            r_in_frame <= n_in_frame;
            r_bit_idx  <= n_bit_idx;
            r_acc      <= n_acc;
            r_pos      <= n_pos;
        end
    end

endmodule

/* sv/sync_word_deframer_descrambler.sv */
// Top level: input register, deframer core, result register and config registers.
// An item is held in the input register, and its result is then held in the result register.
// Throughput: one item per cycle; the only limit is the stall on the result side.
// An item that causes no result leaves the pipe without occupying the result register.
// Synchronous active-low reset clears the hunt state, empties both registers and
// loads the default sync word and keep threshold.
module sync_word_deframer_descrambler #(
    parameter int FRAME_BYTES     = 320,
    parameter int SYNC_BITS       = 32,
    parameter int FIRST_DATA_BYTE = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_opcode,
    input  logic                          i_data_bit,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [swd_pkg::KIND_W-1:0]    o_kind,
    output logic [7:0]                    o_data_byte,
    output logic [swd_pkg::POS_W-1:0]     o_position,
    output logic                          o_frame_last,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [swd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [swd_pkg::CFG_W-1:0]     i_cfg_data
);
    import swd_pkg::*;

    logic             r_in_valid;
    logic             r_opcode;
    logic             r_data_bit;
    logic             r_out_valid;
    t_result          r_out;
    logic [31:0]      r_sync_word;
    logic [POS_W-1:0] r_keep_above;

    logic    out_ready;
    logic    step;
    t_result res;

    assign out_ready   = !r_out_valid || !i_out_stall;
    assign step        = r_in_valid && out_ready;
    assign o_in_stall  = r_in_valid && !out_ready;
    assign o_cfg_ready = 1'b1;

    swd_core #(
        .FRAME_BYTES     (FRAME_BYTES),
        .SYNC_BITS       (SYNC_BITS),
        .FIRST_DATA_BYTE (FIRST_DATA_BYTE)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_opcode     (r_opcode),
        .i_data_bit   (r_data_bit),
        .i_sync_word  (r_sync_word),
        .i_keep_above (r_keep_above),
        .o_result     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (out_ready) begin
                r_out_valid <= step && res.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_opcode   <= i_opcode;
            r_data_bit <= i_data_bit;
        end
        if (step && res.valid) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_word  <= SYNC_WORD_RST;
            r_keep_above <= KEEP_ABOVE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SYNC_WORD:  r_sync_word  <= i_cfg_data[31:0];
                CFG_KEEP_ABOVE: r_keep_above <= i_cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_out.kind;
    assign o_data_byte  = r_out.data_byte;
    assign o_position   = r_out.position;
    assign o_frame_last = r_out.frame_last;

endmodule

/* verif/tb_sync_word_deframer_descrambler.sv */
// Testbench for the sync word deframer: directed table, then random frames vs. a predictor.
module tb_sync_word_deframer_descrambler;
    timeunit 1ns;
    timeprecision 1ps;

    import swd_pkg::*;

    localparam int FRAME_BYTES     = 320;
    localparam int SYNC_BITS       = 32;
    localparam int FIRST_DATA_BYTE = 7;
    localparam int CYCLE_LIMIT     = 800_000;

    localparam logic OP_BIT = 1'b0;
    localparam logic OP_GAP = 1'b1;

    // indexes past the register list, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef enum logic [1:0] {ROW_GAP, ROW_SYNC, ROW_BITS} t_row_kind;

    typedef struct {
        t_row_kind   what;
        int          nbits;
        logic [31:0] value;
        bit          typed;
        t_result     want;
    } t_dir_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_opcode;
    logic                 i_data_bit;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [KIND_W-1:0]    o_kind;
    logic [7:0]           o_data_byte;
    logic [POS_W-1:0]     o_position;
    logic                 o_frame_last;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    sync_word_deframer_descrambler #(
        .FRAME_BYTES    (FRAME_BYTES),
        .SYNC_BITS      (SYNC_BITS),
        .FIRST_DATA_BYTE(FIRST_DATA_BYTE)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_data_bit  (i_data_bit),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_kind      (o_kind),
        .o_data_byte (o_data_byte),
        .o_position  (o_position),
        .o_frame_last(o_frame_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state and its copy of the registers
    logic [31:0]      cfg_sync;
    logic [POS_W-1:0] cfg_keep;
    logic [31:0]      window;
    int               hunt_count;
    logic             framing;
    logic [2:0]       bit_idx;
    logic [7:0]       acc;
    logic [POS_W-1:0] cur_pos;

    t_result owed_reports[$];
    t_result due;
    t_dir_row dir_rows [19];

    int mismatches  = 0;
    int cycles      = 0;
    int items_sent  = 0;
    int burst_left  = 0;
    int stall_left  = 0;
    int stall_pct   = 0;

    function automatic t_result mk_result(logic [KIND_W-1:0] k, logic [7:0] d, int p, logic last);
        t_result r;
        r = '0;
        r.valid      = 1'b1;
        r.kind       = k;
        r.data_byte  = d;
        r.position   = p[POS_W-1:0];
        r.frame_last = last;
        return r;
    endfunction

    function automatic void leave_frame();
        framing = 1'b0;
        bit_idx = '0;
        acc     = '0;
        cur_pos = POS_W'(FIRST_DATA_BYTE);
    endfunction

    function automatic void clear_deframer();
        cfg_sync   = SYNC_WORD_RST;
        cfg_keep   = KEEP_ABOVE_RST;
        window     = '0;
        hunt_count = 0;
        leave_frame();
    endfunction

    // one input item through the deframer; returns 1 when it yields a report
    function automatic bit deframe_step(input logic op, input logic rx_bit, output t_result r);
        logic [POS_W-1:0] pos;
        r = '0;
        r.valid = 1'b1;
        if (op == OP_GAP) begin
            hunt_count = 0;
            if (framing) begin
                r.kind     = (cur_pos > cfg_keep) ? KIND_KEPT : KIND_DROPPED;
                r.position = cur_pos;
                leave_frame();
                return 1'b1;
            end
            leave_frame();
            return 1'b0;
        end
        window = {window[30:0], rx_bit};
        if (hunt_count < SYNC_BITS)
            hunt_count++;
        if (!framing) begin
            if (hunt_count >= SYNC_BITS && window == cfg_sync) begin
                leave_frame();
                framing = 1'b1;
            end
            return 1'b0;
        end
        acc = acc | (8'(rx_bit) << bit_idx);
        if (bit_idx != 3'd7) begin
            bit_idx++;
            return 1'b0;
        end
        bit_idx     = '0;
        pos         = cur_pos;
        r.kind      = KIND_DATA;
        r.data_byte = acc ^ WHITEN_TAB[pos[WHITEN_W-1:0]];
        r.position  = pos;
        acc         = '0;
        cur_pos     = pos + 1'b1;
        r.frame_last = (int'(pos) + 1 >= FRAME_BYTES);
        if (r.frame_last)
            leave_frame();
        return 1'b1;
    endfunction

    task automatic send_item(input logic op, input logic rx_bit, input bit typed,
                             input t_result want);
        int gap;
        t_result r;
        @(negedge i_clk);
        if (burst_left == 0) begin
            if ($urandom_range(0, 9) == 0) begin
                burst_left = 200;
                gap = 0;
            end else begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
            end
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_data_bit <= rx_bit;
        do @(posedge i_clk); while (o_in_stall);
        burst_left--;
        items_sent++;
        if (deframe_step(op, rx_bit, r))
            owed_reports.push_back(typed ? want : r);
    endtask

    // LSB first, as the block packs them
    task automatic send_bits(input logic [31:0] v, input int n, input bit typed,
                             input t_result want);
        for (int i = 0; i < n; i++)
            send_item(OP_BIT, v[i], typed, want);
    endtask

    // leading n bits of the current sync word, MSB first, with optional corruption
    task automatic send_sync(input int n, input logic [31:0] flip);
        for (int i = 31; i >= 32 - n; i--)
            send_item(OP_BIT, cfg_sync[i] ^ flip[i], 1'b0, '0);
    endtask

    task automatic send_frame(input int noise, input int nbytes, input int extra,
                              input bit gap_end);
        send_bits($urandom(), noise, 1'b0, '0);
        send_sync(32, '0);
        repeat (nbytes) send_bits($urandom_range(0, 255), 8, 1'b0, '0);
        send_bits($urandom(), extra, 1'b0, '0);
        if (gap_end)
            send_item(OP_GAP, 1'($urandom_range(0, 1)), 1'b0, '0);
    endtask

    task automatic random_sequence();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            send_frame($urandom_range(0, 6), $urandom_range(0, 24), $urandom_range(0, 7),
                       $urandom_range(0, 4) != 0);
        end else if (pick < 85) begin
            send_bits($urandom(), $urandom_range(0, 6), 1'b0, '0);
            if ($urandom_range(0, 1)) begin
                send_sync(32, 32'h1 << $urandom_range(0, 31));
            end else begin
                send_sync($urandom_range(1, 31), '0);
                send_item(OP_GAP, 1'($urandom_range(0, 1)), 1'b0, '0);
            end
            send_bits($urandom(), $urandom_range(0, 20), 1'b0, '0);
        end else begin
            repeat ($urandom_range(1, 20))
                send_item(($urandom_range(0, 7) == 0) ? OP_GAP : OP_BIT,
                          1'($urandom_range(0, 1)), 1'b0, '0);
        end
    endtask

    // drain: nothing owed, then a short wait for items that yield no report
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (owed_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_SYNC_WORD)
            cfg_sync = val;
        else if (idx == CFG_KEEP_ABOVE)
            cfg_keep = val[POS_W-1:0];
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_left = $urandom_range(10, 150);
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 25;
                2: stall_pct = 50;
                default: stall_pct = 85;
            endcase
        end
        stall_left--;
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (owed_reports.size() == 0) begin
                $error("report with nothing owed: kind %0d position %0d", o_kind, o_position);
                mismatches++;
            end else begin
                due = owed_reports.pop_front();
                check_field("kind", due.kind, o_kind);
                check_field("data_byte", due.data_byte, o_data_byte);
                check_field("position", due.position, o_position);
                check_field("frame_last", due.frame_last, o_frame_last);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int          keep;
        logic [31:0] sw;
        logic [31:0] kv;
        int          start;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_opcode    = OP_BIT;
        i_data_bit  = 1'b0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_SYNC_WORD;
        i_cfg_data  = '0;
        clear_deframer();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers: default sync word, keep threshold 300
        dir_rows = '{
            '{ROW_GAP,  1, 32'h1,    1'b0, t_result'(0)},
            '{ROW_BITS, 3, 32'h5,    1'b0, t_result'(0)},
            '{ROW_SYNC, 32, 32'h0,   1'b0, t_result'(0)},
            '{ROW_BITS, 8, 32'h96,   1'b1, mk_result(KIND_DATA, 8'h0E, 7, 1'b0)},
            '{ROW_BITS, 8, 32'hFF,   1'b1, mk_result(KIND_DATA, 8'hCD, 8, 1'b0)},
            '{ROW_BITS, 8, 32'h00,   1'b1, mk_result(KIND_DATA, 8'h05, 9, 1'b0)},
            '{ROW_BITS, 5, 32'h1F,   1'b0, t_result'(0)},
            '{ROW_GAP,  0, 32'h0,    1'b1, mk_result(KIND_DROPPED, 8'h00, 10, 1'b0)},
            '{ROW_GAP,  0, 32'h0,    1'b0, t_result'(0)},
            '{ROW_SYNC, 31, 32'h0,   1'b0, t_result'(0)},
            '{ROW_GAP,  0, 32'h0,    1'b0, t_result'(0)},
            '{ROW_SYNC, 32, 32'h0,   1'b0, t_result'(0)},
            '{ROW_BITS, 8, 32'h55,   1'b1, mk_result(KIND_DATA, 8'hCD, 7, 1'b0)},
            '{ROW_GAP,  1, 32'h1,    1'b1, mk_result(KIND_DROPPED, 8'h00, 8, 1'b0)},
            '{ROW_SYNC, 32, 32'h1,   1'b0, t_result'(0)},
            '{ROW_SYNC, 32, 32'h0,   1'b0, t_result'(0)},
            '{ROW_BITS, 16, 32'hA5C3, 1'b0, t_result'(0)},
            '{ROW_BITS, 1, 32'h1,    1'b0, t_result'(0)},
            '{ROW_GAP,  0, 32'h0,    1'b0, t_result'(0)}
        };
        foreach (dir_rows[i]) begin
            case (dir_rows[i].what)
                ROW_GAP:  send_item(OP_GAP, dir_rows[i].nbits[0], dir_rows[i].typed,
                                    dir_rows[i].want);
                ROW_SYNC: send_sync(dir_rows[i].nbits, dir_rows[i].value);
                default:  send_bits(dir_rows[i].value, dir_rows[i].nbits, dir_rows[i].typed,
                                    dir_rows[i].want);
            endcase
        end

        for (int ph = 0; ph < 5; ph++) begin
            settle();
            if (ph == 0) begin
                write_reg(CFG_SPARE_2, $urandom());
                write_reg(CFG_SPARE_3, $urandom());
            end
            case (ph)
                0: begin sw = $urandom();    keep = 0;   end
                1: begin sw = 32'h0;         keep = 320; end
                2: begin sw = 32'hFFFF_FFFF; keep = $urandom_range(0, 320); end
                3: begin sw = $urandom();    keep = 300; end
                default: begin sw = $urandom(); keep = $urandom_range(7, 40); end
            endcase
            kv = $urandom();
            kv[POS_W-1:0] = POS_W'(keep);
            write_reg(CFG_SYNC_WORD, sw);
            write_reg(CFG_KEEP_ABOVE, kv);
            start = items_sent;
            while (items_sent - start < 190)
                random_sequence();
        end

        settle();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
sv/swd_pkg.sv
sv/swd_core.sv
sv/sync_word_deframer_descrambler.sv
verif/tb_sync_word_deframer_descrambler.sv
